// File: rtl/cpr_pkg.sv
// Package for the clock page replacement block: sequencer states and fixed widths.
// Used by clock_page_replacement; no dependencies.
package cpr_pkg;

    localparam int CFG_W   = 4;
    localparam int FAULT_W = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWEEP,
        ST_EVICT,
        ST_DONE
    } cpr_state_t;

endpackage

// File: rtl/cpr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/clock_page_replacement.sv
// Clock (second-chance) page replacement; page table held in cpr_ram, depends on cpr_pkg.
// A hit stops at the matching frame; a miss scans all n active frames, then a cold fill
// finishes at once, or a replacement runs the use-bit sweep, then the evicting read-write.
// One item in flight; the next is taken the cycle after the result enters the output register.
// Reset (synchronous, active low) clears valid/use bits, hand, fill and fault counts.
module clock_page_replacement
    import cpr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_W-1:0]          cfg_frames_in_use,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [PAGE_BITS-1:0]      s_page,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic                      m_replaced,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] m_frame_index,
    output logic [PAGE_BITS-1:0]      m_evicted_page,
    output logic [FAULT_W-1:0]        m_fault_count
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    cpr_state_t state_reg, state_next;

    logic [CFG_W-1:0]     cfg_reg;
    logic [CNT_W-1:0]     n_reg, n_next, n_active;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     h_reg, h_next;
    logic [IDX_W-1:0]     hand_reg, hand_next;
    logic [CNT_W-1:0]     filled_reg, filled_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;
    logic [FRAMES-1:0]    valid_reg, valid_next;
    logic [FRAMES-1:0]    use_reg, use_next;

    logic                 res_hit_reg, res_hit_next;
    logic                 res_repl_reg, res_repl_next;
    logic [IDX_W-1:0]     res_frame_reg, res_frame_next;
    logic [PAGE_BITS-1:0] res_evict_reg, res_evict_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_hit_reg, m_hit_next;
    logic                 m_repl_reg, m_repl_next;
    logic [IDX_W-1:0]     m_frame_reg, m_frame_next;
    logic [PAGE_BITS-1:0] m_evict_reg, m_evict_next;
    logic [FAULT_W-1:0]   m_fault_reg, m_fault_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [PAGE_BITS-1:0] ram_rdata;

    logic                 match, last_cmp, fill_go, out_free, h_wrap;
    logic [IDX_W-1:0]     hand_start, h_inc;
    logic [CNT_W-1:0]     filled_inc;

    cpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_pages (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (page_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (cfg_reg == '0) begin
            n_active = CNT_W'(1);
        end else if (32'(cfg_reg) > 32'(FRAMES)) begin
            n_active = CNT_W'(FRAMES);
        end else begin
            n_active = CNT_W'(cfg_reg);
        end
    end

    assign match      = cmp_vld_reg && valid_reg[cmp_idx_reg] && (ram_rdata == page_reg);
    assign last_cmp   = cmp_vld_reg && ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == n_reg);
    assign fill_go    = filled_reg < n_reg;
    assign filled_inc = filled_reg + CNT_W'(1);
    assign hand_start = (CNT_W'(hand_reg) < n_reg) ? hand_reg : '0;
    assign h_wrap     = (CNT_W'(h_reg) + CNT_W'(1)) == n_reg;
    assign h_inc      = h_wrap ? '0 : h_reg + IDX_W'(1);
    assign out_free   = !m_valid_reg || m_ready;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_replaced     = m_repl_reg;
    assign m_frame_index  = m_frame_reg;
    assign m_evicted_page = m_evict_reg;
    assign m_fault_count  = m_fault_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (match) begin
                    state_next = ST_DONE;
                end else if (last_cmp) begin
                    state_next = fill_go ? ST_DONE : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (!use_reg[h_reg]) begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_next         = n_reg;
        page_next      = page_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        h_next         = h_reg;
        hand_next      = hand_reg;
        filled_next    = filled_reg;
        fault_next     = fault_reg;
        valid_next     = valid_reg;
        use_next       = use_reg;
        res_hit_next   = res_hit_reg;
        res_repl_next  = res_repl_reg;
        res_frame_next = res_frame_reg;
        res_evict_next = res_evict_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_hit_next     = m_hit_reg;
        m_repl_next    = m_repl_reg;
        m_frame_next   = m_frame_reg;
        m_evict_next   = m_evict_reg;
        m_fault_next   = m_fault_reg;
        ram_we         = 1'b0;
        ram_waddr      = h_reg;
        ram_raddr      = rd_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    page_next    = s_page;
                    n_next       = n_active;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                end
            end
            ST_SEARCH: begin
                rd_idx_next  = rd_idx_reg + IDX_W'(1);
                cmp_vld_next = 1'b1;
                cmp_idx_next = rd_idx_reg;
                if (match) begin
                    use_next[cmp_idx_reg] = 1'b1;
                    res_hit_next   = 1'b1;
                    res_repl_next  = 1'b0;
                    res_frame_next = cmp_idx_reg;
                    res_evict_next = '0;
                end else if (last_cmp) begin
                    if (fill_go) begin
                        // cold fill into the next free frame
                        ram_we    = 1'b1;
                        ram_waddr = filled_reg[IDX_W-1:0];
                        valid_next[filled_reg[IDX_W-1:0]] = 1'b1;
                        use_next[filled_reg[IDX_W-1:0]]   = 1'b1;
                        filled_next    = filled_inc;
                        hand_next      = (filled_inc == n_reg) ? '0 : filled_inc[IDX_W-1:0];
                        res_hit_next   = 1'b0;
                        res_repl_next  = 1'b0;
                        res_frame_next = filled_reg[IDX_W-1:0];
                        res_evict_next = '0;
                    end else begin
                        h_next = hand_start;
                    end
                end
            end
            ST_SWEEP: begin
                if (use_reg[h_reg]) begin
                    use_next[h_reg] = 1'b0;
                    h_next          = h_inc;
                end else begin
                    ram_raddr = h_reg;
                end
            end
            ST_EVICT: begin
                ram_we    = 1'b1;
                ram_waddr = h_reg;
                valid_next[h_reg] = 1'b1;
                use_next[h_reg]   = 1'b1;
                hand_next         = h_inc;
                if (fault_reg != FAULT_MAX) begin
                    fault_next = fault_reg + FAULT_W'(1);
                end
                res_hit_next   = 1'b0;
                res_repl_next  = 1'b1;
                res_frame_next = h_reg;
                res_evict_next = valid_reg[h_reg] ? ram_rdata : '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_repl_next  = res_repl_reg;
                    m_frame_next = res_frame_reg;
                    m_evict_next = res_evict_reg;
                    m_fault_next = fault_reg;
                end
            end
            default: begin
                cmp_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_RESET;
            cmp_vld_reg <= 1'b0;
            hand_reg    <= '0;
            filled_reg  <= '0;
            fault_reg   <= '0;
            valid_reg   <= '0;
            use_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_frames_in_use;
            end
            cmp_vld_reg <= cmp_vld_next;
            hand_reg    <= hand_next;
            filled_reg  <= filled_next;
            fault_reg   <= fault_next;
            valid_reg   <= valid_next;
            use_reg     <= use_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        page_reg      <= page_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        h_reg         <= h_next;
        res_hit_reg   <= res_hit_next;
        res_repl_reg  <= res_repl_next;
        res_frame_reg <= res_frame_next;
        res_evict_reg <= res_evict_next;
        m_hit_reg     <= m_hit_next;
        m_repl_reg    <= m_repl_next;
        m_frame_reg   <= m_frame_next;
        m_evict_reg   <= m_evict_next;
        m_fault_reg   <= m_fault_next;
    end

endmodule
